@@ src/framed_packet_checker_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the framed packet checker
// Concurrent assertion wrappers; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef FRAMED_PACKET_CHECKER_CORE_ASSERT_SVH
`define FRAMED_PACKET_CHECKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define FPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define FPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FPC_ASSERT(lbl, clk, rst, prop, msg)

`define FPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ src/fpc_pkg.sv @@
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared constants, types and the CRC-32/MPEG-2 update matrix.
// ----------------------------------------------------------------------------
package fpc_pkg;

   localparam int MAX_WORDS_DEF = 256;

   localparam logic [15:0] PREAMBLE_CODE  = 16'h484C;
   localparam logic [31:0] CRC_POLY       = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_TOP        = 32'h8000_0000;
   localparam logic [4:0]  FRAME_OVERHEAD = 5'd12;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_PREAMBLE,
      STATUS_BAD_LENGTH,
      STATUS_BAD_CRC
   } status_type;

   typedef struct packed {
      logic [31:0] first;
      logic [31:0] second;
   } fpc_hdr_type;

   typedef logic [31:0][31:0] crc_matrix_type;

   // 32 zero bits through the MSB-first shift register
   function automatic logic [31:0] crc_shift_zeros(input logic [31:0] crc_in);
      logic [31:0] crc;
      logic        top;
      crc = crc_in;
      for (int k = 0; k < 32; k++) begin
         top = (crc & CRC_TOP) != 32'd0;
         crc = crc << 1;
         if (top) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

   // row j: which bits of (crc ^ word) feed next-crc bit j
   function automatic crc_matrix_type crc_rows();
      crc_matrix_type rows;
      logic [31:0]    col;
      rows = '0;
      for (int i = 0; i < 32; i++) begin
         col = crc_shift_zeros(32'd1 << i);
         for (int j = 0; j < 32; j++) begin
            rows[j][i] = col[j];
         end
      end
      return rows;
   endfunction

   localparam crc_matrix_type CRC_ROWS = crc_rows();

endpackage

@@ src/fpc_crc.sv @@
// ----------------------------------------------------------------------------
// fpc_crc
// Parallel CRC-32/MPEG-2 update over one 32-bit word.
// ----------------------------------------------------------------------------
module fpc_crc
   import fpc_pkg::*;
(
   input  logic [31:0] crc_i,
   input  logic [31:0] data_i,
   output logic [31:0] crc_o
);

   logic [31:0] mix;

   assign mix = crc_i ^ data_i;

   always_comb begin
      for (int j = 0; j < 32; j++) begin
         crc_o[j] = ^(mix & CRC_ROWS[j]);
      end
   end

endmodule

@@ src/fpc_verdict.sv @@
// ----------------------------------------------------------------------------
// fpc_verdict
// Packet verdict on the CRC word: preamble, length, then CRC.
// ----------------------------------------------------------------------------
module fpc_verdict
   import fpc_pkg::*;
#(
   parameter int MAX_WORDS = MAX_WORDS_DEF,
   parameter int CNT_W     = $clog2(MAX_WORDS + 1)
) (
   input  fpc_hdr_type      hdr_i,
   input  logic [CNT_W-1:0] count_i,
   input  logic [31:0]      crc_word_i,
   input  logic [31:0]      crc_calc_i,
   output status_type       status_o
);

   localparam int TOT_W = CNT_W + 1;
   localparam int LEN_W = (TOT_W + 2 > 17) ? TOT_W + 2 : 17;

   logic [TOT_W-1:0] total;
   logic [LEN_W-1:0] pkt_bytes;
   logic [LEN_W-1:0] exp_bytes;
   logic             bad_len;

   assign total     = TOT_W'(count_i) + TOT_W'(1);
   assign pkt_bytes = LEN_W'(total) << 2;
   assign exp_bytes = LEN_W'(hdr_i.second[31:16]) + LEN_W'(FRAME_OVERHEAD);
   assign bad_len   = (total < TOT_W'(3)) || (total > TOT_W'(MAX_WORDS)) ||
                      (pkt_bytes != exp_bytes);

   always_comb begin
      if (hdr_i.first[15:0] != PREAMBLE_CODE) begin
         status_o = STATUS_BAD_PREAMBLE;
      end else if (bad_len) begin
         status_o = STATUS_BAD_LENGTH;
      end else if (crc_word_i != crc_calc_i) begin
         status_o = STATUS_BAD_CRC;
      end else begin
         status_o = STATUS_OK;
      end
   end

endmodule

@@ src/framed_packet_checker_core.sv @@
// ----------------------------------------------------------------------------
// framed_packet_checker_core
// Header, length and CRC-32 check of framed packets, one word per transaction.
// ----------------------------------------------------------------------------
// Accepts one packet word per clock cycle, back to back, across packets, but a last
// word waits while the result register holds a stalled verdict. A word is
// registered, then in the next cycle the 32-bit parallel CRC update and the verdict
// logic act on it; the verdict of a packet goes to the result register when its last
// word is processed and is held on rsp_ while rsp_stall is high. Only the last word
// of a packet needs the result register, so non-final words keep flowing while a
// verdict waits. Packets longer than MAX_WORDS words with a good preamble are reported as bad length.
`include "framed_packet_checker_core_assert.svh"

module framed_packet_checker_core
   import fpc_pkg::*;
#(
   parameter int MAX_WORDS = MAX_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_word,
   input  logic        req_last_word,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_payload_len,
   output logic [15:0] rsp_command,
   output logic [15:0] rsp_sequence_res
);

   localparam int CNT_W = $clog2(MAX_WORDS + 1);

   logic             in_vld_ff,  in_vld_in;
   logic [31:0]      in_word_ff, in_word_in;
   logic             in_last_ff, in_last_in;

   logic [31:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   fpc_hdr_type      hdr_ff, hdr_in;

   logic             out_vld_ff,    out_vld_in;
   status_type       out_status_ff, out_status_in;
   logic [15:0]      out_plen_ff,   out_plen_in;
   logic [15:0]      out_cmd_ff,    out_cmd_in;
   logic [15:0]      out_seq_ff,    out_seq_in;

   logic             out_free;
   logic             proc;
   logic             in_free;
   fpc_hdr_type      hdr_cur;
   logic [31:0]      crc_next;
   status_type       verdict;

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign proc      = in_vld_ff && (!in_last_ff || out_free);
   assign in_free   = !in_vld_ff || proc;
   assign req_stall = !in_free;

   // header words are captured by position, also when that word is the last
   assign hdr_cur.first  = (cnt_ff == CNT_W'(0)) ? in_word_ff : hdr_ff.first;
   assign hdr_cur.second = (cnt_ff == CNT_W'(1)) ? in_word_ff : hdr_ff.second;

   fpc_crc u_crc (
      .crc_i  (crc_ff),
      .data_i (in_word_ff),
      .crc_o  (crc_next)
   );

   fpc_verdict #(
      .MAX_WORDS (MAX_WORDS),
      .CNT_W     (CNT_W)
   ) u_verdict (
      .hdr_i      (hdr_cur),
      .count_i    (cnt_ff),
      .crc_word_i (in_word_ff),
      .crc_calc_i (crc_ff),
      .status_o   (verdict)
   );

   // input register
   always_comb begin
      in_vld_in  = in_vld_ff;
      in_word_in = in_word_ff;
      in_last_in = in_last_ff;
      if (in_free) begin
         in_vld_in  = req_valid;
         in_word_in = req_word;
         in_last_in = req_last_word;
      end
   end

   // packet state
   always_comb begin
      crc_in = crc_ff;
      cnt_in = cnt_ff;
      hdr_in = hdr_ff;
      if (proc) begin
         if (in_last_ff) begin
            crc_in = CRC_INIT;
            cnt_in = '0;
            hdr_in = '0;
         end else begin
            crc_in = crc_next;
            hdr_in = hdr_cur;
            if (cnt_ff < CNT_W'(MAX_WORDS)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   // result register
   always_comb begin
      out_vld_in    = out_vld_ff;
      out_status_in = out_status_ff;
      out_plen_in   = out_plen_ff;
      out_cmd_in    = out_cmd_ff;
      out_seq_in    = out_seq_ff;
      if (proc && in_last_ff) begin
         out_vld_in    = 1'b1;
         out_status_in = verdict;
         out_plen_in   = hdr_cur.second[31:16];
         out_cmd_in    = hdr_cur.first[31:16];
         out_seq_in    = hdr_cur.second[15:0];
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         crc_ff     <= CRC_INIT;
         cnt_ff     <= '0;
         hdr_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         crc_ff     <= crc_in;
         cnt_ff     <= cnt_in;
         hdr_ff     <= hdr_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff    <= in_word_in;
      in_last_ff    <= in_last_in;
      out_status_ff <= out_status_in;
      out_plen_ff   <= out_plen_in;
      out_cmd_ff    <= out_cmd_in;
      out_seq_ff    <= out_seq_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_payload_len  = out_plen_ff;
   assign rsp_command      = out_cmd_ff;
   assign rsp_sequence_res = out_seq_ff;

   `FPC_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(MAX_WORDS), "word count past capacity")

   `FPC_ASSERT_NEXT(a_last_gives_rsp, clock, reset, proc && in_last_ff, out_vld_ff, "last word gave no verdict")

   `FPC_ASSERT_NEXT(a_last_clears, clock, reset, proc && in_last_ff, cnt_ff == '0 && crc_ff == CRC_INIT, "packet state not cleared")

   `FPC_ASSERT_NEXT(a_mid_no_rsp, clock, reset, !out_vld_ff && !(proc && in_last_ff), !out_vld_ff, "verdict without last word")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for framed_packet_checker_core: sends framed packets
// (good, bad preamble, bad length, bad CRC, noise, over-capacity) word by word
// under random idling and output stalls, predicts each packet verdict and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module tb;
   import fpc_pkg::*;

   localparam int MAX_WORDS   = MAX_WORDS_DEF;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum {FR_GOOD, FR_BAD_PREAMBLE, FR_BAD_LENGTH, FR_BAD_CRC, FR_NOISE} frame_kind_type;

   class packet_verdict_board;
      typedef struct {
         status_type  status;
         logic [15:0] plen;
         logic [15:0] cmd;
         logic [15:0] seq;
      } verdict_type;

      verdict_type pending[$];
      logic [31:0] crc_acc;
      int unsigned nwords;
      logic [31:0] hdr0;
      logic [31:0] hdr1;
      int unsigned cap;
      int          errors;
      int          checked;

      function new(int unsigned cap_words);
         cap     = cap_words;
         errors  = 0;
         checked = 0;
         clear();
      endfunction

      function void clear();
         crc_acc = CRC_INIT;
         nwords  = 0;
         hdr0    = '0;
         hdr1    = '0;
      endfunction

      static function logic [31:0] crc_next(logic [31:0] c, logic [31:0] d);
         logic top;
         for (int k = 31; k >= 0; k--) begin
            top = c[31];
            c   = {c[30:0], 1'b0};
            if (top ^ d[k]) begin
               c = c ^ CRC_POLY;
            end
         end
         return c;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) begin
            $display("MISMATCH: %s", msg);
         end
      endfunction

      function void note_word(logic [31:0] w, logic fin);
         verdict_type v;
         int          total;
         logic [15:0] plen;
         if (nwords == 0) begin
            hdr0 = w;
         end else if (nwords == 1) begin
            hdr1 = w;
         end
         if (!fin) begin
            crc_acc = crc_next(crc_acc, w);
            if (nwords < cap) begin
               nwords++;
            end
            return;
         end
         total = nwords + 1;
         plen  = hdr1[31:16];
         if (hdr0[15:0] != PREAMBLE_CODE) begin
            v.status = STATUS_BAD_PREAMBLE;
         end else if (total < 3 || total > cap ||
                      total * 4 != int'(plen) + int'(FRAME_OVERHEAD)) begin
            v.status = STATUS_BAD_LENGTH;
         end else if (w != crc_acc) begin
            v.status = STATUS_BAD_CRC;
         end else begin
            v.status = STATUS_OK;
         end
         v.plen = plen;
         v.cmd  = hdr0[31:16];
         v.seq  = hdr1[15:0];
         pending.push_back(v);
         clear();
      endfunction

      function void check_result(logic [1:0] st, logic [15:0] pl, logic [15:0] cm,
                                 logic [15:0] sq);
         verdict_type v;
         checked++;
         if (pending.size() == 0) begin
            flag($sformatf("unexpected verdict status=%0d len=%h cmd=%h seq=%h",
                           st, pl, cm, sq));
            return;
         end
         v = pending.pop_front();
         if (st !== v.status || pl !== v.plen || cm !== v.cmd || sq !== v.seq) begin
            flag($sformatf({"expected status=%0d len=%h cmd=%h seq=%h, ",
                            "got status=%0d len=%h cmd=%h seq=%h"},
                           v.status, v.plen, v.cmd, v.seq, st, pl, cm, sq));
         end
      endfunction
   endclass

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [31:0] req_word      = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_payload_len;
   logic [15:0] rsp_command;
   logic [15:0] rsp_sequence_res;

   packet_verdict_board sb;
   logic        idle_on    = 1'b1;
   int          stall_left = 0;
   int          cycles     = 0;

   framed_packet_checker_core #(.MAX_WORDS(MAX_WORDS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .req_last_word    (req_last_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_payload_len  (rsp_payload_len),
      .rsp_command      (rsp_command),
      .rsp_sequence_res (rsp_sequence_res)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side: check accepted verdicts, stall in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_status, rsp_payload_len, rsp_command, rsp_sequence_res);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 14);
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_word(input logic [31:0] w, input logic fin);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid     <= 1'b0;
         req_word      <= $urandom;
         req_last_word <= 1'($urandom_range(0, 1));
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_word      <= w;
      req_last_word <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(w, fin);
   endtask

   task automatic send_frame(input logic [31:0] q[$]);
      for (int i = 0; i < q.size(); i++) begin
         send_word(q[i], i == q.size() - 1);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic void seal(ref logic [31:0] q[$]);
      logic [31:0] c;
      c = CRC_INIT;
      foreach (q[i]) c = packet_verdict_board::crc_next(c, q[i]);
      q.push_back(c);
   endfunction

   function automatic void make_frame(ref logic [31:0] q[$], input int n,
                                      input frame_kind_type kind);
      logic [31:0] r0;
      logic [31:0] r1;
      logic [15:0] plen;
      r0   = $urandom;
      r1   = $urandom;
      plen = 16'(4 * n - 12);
      q.delete();
      q.push_back({r0[31:16], PREAMBLE_CODE});
      q.push_back({plen, r1[15:0]});
      if (kind == FR_BAD_PREAMBLE) begin
         q[0][15:0] = PREAMBLE_CODE ^ 16'($urandom_range(1, 65535));
      end
      if (kind == FR_BAD_LENGTH) begin
         q[1][31:16] = q[1][31:16] ^ 16'($urandom_range(1, 65535));
      end
      for (int i = 2; i < n - 1; i++) begin
         q.push_back($urandom);
      end
      if (n >= 3) begin
         seal(q);
      end
      if (kind == FR_BAD_CRC && n >= 3) begin
         q[n - 1] = q[n - 1] ^ ((32'd1 << $urandom_range(0, 31)) | $urandom);
      end
      if (kind == FR_NOISE) begin
         foreach (q[i]) q[i] = $urandom;
      end
   endfunction

   initial begin
      logic [31:0]    q[$];
      frame_kind_type kind;
      int             n;
      int             r;
      int             pk;
      int             words_sent;

      sb = new(MAX_WORDS);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames
      q = '{{16'hFFFF, PREAMBLE_CODE}, 32'h0000_0000};
      seal(q);
      send_frame(q);
      q = '{{16'h0000, PREAMBLE_CODE}, 32'hFFFF_FFFF};
      send_frame(q);
      q = '{{16'h0000, PREAMBLE_CODE ^ 16'h8001}, {16'd0, 16'hFFFF}};
      seal(q);
      send_frame(q);
      q = '{{16'h1234, PREAMBLE_CODE}, {16'd4, 16'h8000}, 32'hFFFF_FFFF};
      seal(q);
      q[3] = q[3] ^ 32'h0000_0001;
      send_frame(q);
      q = '{{16'h8000, PREAMBLE_CODE}, {16'd9, 16'h0001}, 32'h0, 32'h0};
      seal(q);
      q[4] = q[4] ^ 32'h8000_0000;
      send_frame(q);
      q = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000};
      send_frame(q);
      drain();

      // random frames, mostly well formed, one at capacity and one past it
      pk         = 0;
      words_sent = 0;
      while (words_sent < 540) begin
         idle_on <= ((pk % 16) < 12);
         r = $urandom_range(0, 99);
         kind = (r < 50) ? FR_GOOD : (r < 65) ? FR_BAD_CRC : (r < 80) ? FR_BAD_LENGTH :
                (r < 90) ? FR_BAD_PREAMBLE : FR_NOISE;
         n = $urandom_range(2, 12);
         if (pk == 4) begin
            n    = MAX_WORDS;
            kind = FR_GOOD;
         end else if (pk == 9) begin
            n = MAX_WORDS + 1 + $urandom_range(0, 8);
         end
         make_frame(q, n, kind);
         send_frame(q);
         words_sent += n;
         if (pk % 5 == 2) begin
            drain();
         end
         pk++;
      end

      // closing stretch at full rate
      idle_on <= 1'b0;
      for (int i = 0; i < 10; i++) begin
         make_frame(q, $urandom_range(3, 8), FR_GOOD);
         send_frame(q);
      end
      drain();
      repeat (8) @(posedge clock);

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
